FILE: src/rbd_pkg.sv
package rbd_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int CMD_BITS   = 3;
    localparam int VALUE_BITS = 32;
    localparam int RING_BITS  = 5;
    localparam int APB_BITS   = 32;
    localparam int ADDR_BITS  = 3;

    localparam logic [RING_BITS-1:0] RING_SIZE_RESET = 5'd16;
    localparam logic                 REG_RING_SIZE   = 1'b0;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_PEEK_BACK  = 3'd4,
        CMD_PEEK_FRONT = 3'd5
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic is_read;
        logic is_full;
        logic is_empty;
    } t_status;

endpackage

FILE: src/rbd_ram.sv
module rbd_ram #(
    parameter int WIDTH = rbd_pkg::WORD_BITS_DEF,
    parameter int DEPTH = rbd_pkg::SLOTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/rbd_ctrl.sv
module rbd_ctrl #(
    parameter int SLOTS     = rbd_pkg::SLOTS_DEF,
    parameter int WORD_BITS = rbd_pkg::WORD_BITS_DEF,
    localparam int PW       = $clog2(SLOTS),
    localparam int SW       = $clog2(SLOTS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [rbd_pkg::CMD_BITS-1:0]    i_command,
    input  logic [rbd_pkg::VALUE_BITS-1:0]  i_push_value,
    input  logic [rbd_pkg::RING_BITS-1:0]   i_ring_size,
    input  logic                            i_clear,
    output logic                            o_ram_we,
    output logic                            o_ram_re,
    output logic [PW-1:0]                   o_ram_addr,
    output logic [WORD_BITS-1:0]            o_ram_wdata,
    output rbd_pkg::t_status                o_status
);

    logic [PW-1:0] r_front, n_front;
    logic [PW-1:0] r_back,  n_back;
    logic [31:0]   ring32;
    logic [SW-1:0] size;
    logic [SW-1:0] f, b, nf, nb;
    logic          empty, full;
    logic          ok, we, re;
    logic [SW-1:0] addr;

    function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p, input logic [SW-1:0] n);
        logic [SW:0] s;
        s = {1'b0, p} + {{SW{1'b0}}, 1'b1};
        return (s >= {1'b0, n}) ? '0 : s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] ptr_dec(input logic [SW-1:0] p, input logic [SW-1:0] n);
        return (p == '0) ? n - SW'(1) : p - SW'(1);
    endfunction

    always_comb begin
        ring32 = {{(32 - rbd_pkg::RING_BITS){1'b0}}, i_ring_size};
        if (ring32 < 32'd2) begin
            size = SW'(2);
        end else if (ring32 > 32'(SLOTS)) begin
            size = SW'(SLOTS);
        end else begin
            size = ring32[SW-1:0];
        end
    end

    always_comb begin
        f = (SW'(r_front) >= size) ? '0 : SW'(r_front);
        b = (SW'(r_back) >= size) ? '0 : SW'(r_back);
        empty = (f == b);
        full  = (ptr_inc(b, size) == f);
        nf   = f;
        nb   = b;
        ok   = 1'b0;
        we   = 1'b0;
        re   = 1'b0;
        addr = b;
        unique case (rbd_pkg::t_cmd'(i_command))
            rbd_pkg::CMD_PUSH_BACK: begin
                if (!full) begin
                    we   = 1'b1;
                    addr = b;
                    nb   = ptr_inc(b, size);
                    ok   = 1'b1;
                end
            end
            rbd_pkg::CMD_PUSH_FRONT: begin
                if (!full) begin
                    we   = 1'b1;
                    nf   = ptr_dec(f, size);
                    addr = ptr_dec(f, size);
                    ok   = 1'b1;
                end
            end
            rbd_pkg::CMD_POP_BACK: begin
                if (!empty) begin
                    re   = 1'b1;
                    nb   = ptr_dec(b, size);
                    addr = ptr_dec(b, size);
                    ok   = 1'b1;
                end
            end
            rbd_pkg::CMD_POP_FRONT: begin
                if (!empty) begin
                    re   = 1'b1;
                    addr = f;
                    nf   = ptr_inc(f, size);
                    ok   = 1'b1;
                end
            end
            rbd_pkg::CMD_PEEK_BACK: begin
                if (!empty) begin
                    re   = 1'b1;
                    addr = ptr_dec(b, size);
                    ok   = 1'b1;
                end
            end
            rbd_pkg::CMD_PEEK_FRONT: begin
                if (!empty) begin
                    re   = 1'b1;
                    addr = f;
                    ok   = 1'b1;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign n_front = i_accept ? PW'(nf) : r_front;
    assign n_back  = i_accept ? PW'(nb) : r_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_front <= '0;
            r_back  <= '0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
        end
    end

    assign o_ram_we    = i_accept && we;
    assign o_ram_re    = i_accept && re;
    assign o_ram_addr  = PW'(addr);
    assign o_ram_wdata = WORD_BITS'(i_push_value);

    assign o_status.ok       = ok;
    assign o_status.is_read  = re;
    assign o_status.is_full  = (ptr_inc(nb, size) == nf);
    assign o_status.is_empty = (nf == nb);

endmodule

FILE: src/ring_buffer_deque.sv
// Channel       Direction  tdata                 tuser
// s_axis        in         [31:0] push_value     [2:0] command
// m_axis        out        [31:0] read_value     [0] ok, [1] is_full, [2] is_empty
// APB           in/out     register 0 at byte address 0: ring_size [4:0]
//
// From transfer to result, a command passes the slot memory's registered read and then the
// output register; the pointer update and the slot access happen in the accept cycle.
// Commands can be accepted in every cycle; a held result on m_axis stalls s_axis only
// once the slot-read stage behind it is occupied as well.
// Reset is synchronous; it empties the queue and sets ring_size to 16. Slot contents are
// not cleared. Writing ring_size also empties the queue.
module ring_buffer_deque #(
    parameter int SLOTS     = rbd_pkg::SLOTS_DEF,
    parameter int WORD_BITS = rbd_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rbd_pkg::VALUE_BITS-1:0]  s_axis_tdata,   // [31:0] push_value
    input  logic [rbd_pkg::CMD_BITS-1:0]    s_axis_tuser,   // [2:0] command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rbd_pkg::VALUE_BITS-1:0]  m_axis_tdata,   // [31:0] read_value
    output logic [2:0]                      m_axis_tuser,   // [0] ok, [1] is_full, [2] is_empty
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rbd_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [rbd_pkg::APB_BITS-1:0]    pwdata,
    output logic [rbd_pkg::APB_BITS-1:0]    prdata,
    output logic                            pready
);

    localparam int PW = $clog2(SLOTS);

    logic [rbd_pkg::RING_BITS-1:0]  r_ring_size;
    logic                           cfg_write;
    logic                           accept;
    logic                           advance;
    logic                           r_busy, n_busy;
    rbd_pkg::t_status               r_status;
    rbd_pkg::t_status               status;
    logic                           r_out_valid, n_out_valid;
    logic [rbd_pkg::VALUE_BITS-1:0] r_out_data;
    logic [2:0]                     r_out_user;
    logic                           ram_we, ram_re;
    logic [PW-1:0]                  ram_addr;
    logic [WORD_BITS-1:0]           ram_wdata, ram_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == rbd_pkg::REG_RING_SIZE);
    assign prdata    = (paddr[2] == rbd_pkg::REG_RING_SIZE)
                       ? {{(rbd_pkg::APB_BITS - rbd_pkg::RING_BITS){1'b0}}, r_ring_size}
                       : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= rbd_pkg::RING_SIZE_RESET;
        end else if (cfg_write) begin
            r_ring_size <= pwdata[rbd_pkg::RING_BITS-1:0];
        end
    end

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_busy || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rbd_ctrl #(
        .SLOTS     (SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (s_axis_tuser),
        .i_push_value (s_axis_tdata),
        .i_ring_size  (r_ring_size),
        .i_clear      (cfg_write),
        .o_ram_we     (ram_we),
        .o_ram_re     (ram_re),
        .o_ram_addr   (ram_addr),
        .o_ram_wdata  (ram_wdata),
        .o_status     (status)
    );

    rbd_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_busy = r_busy;
        if (accept) begin
            n_busy = 1'b1;
        end else if (advance) begin
            n_busy = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (r_busy && advance) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= status;
        end
        if (r_busy && advance) begin
            r_out_data <= r_status.is_read ? rbd_pkg::VALUE_BITS'(ram_rdata) : '0;
            r_out_user <= {r_status.is_empty, r_status.is_full, r_status.ok};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rbd_pkg::CMD_BITS-1:0]  CMD_UNUSED_6 = 3'd6;
    localparam logic [rbd_pkg::CMD_BITS-1:0]  CMD_UNUSED_7 = 3'd7;
    localparam logic [rbd_pkg::ADDR_BITS-1:0] RING_ADDR    =
        rbd_pkg::ADDR_BITS'(4 * rbd_pkg::REG_RING_SIZE);
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 102;

    typedef struct packed {
        logic                           ok;
        logic [rbd_pkg::VALUE_BITS-1:0] read_value;
        logic                           is_full;
        logic                           is_empty;
    } t_deque_result;

    typedef struct packed {
        logic                         is_cfg;
        logic [rbd_pkg::CMD_BITS-1:0] cmd;
        logic [rbd_pkg::APB_BITS-1:0] word;
        logic                         typed;
        t_deque_result                want;
    } t_stim_row;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [rbd_pkg::VALUE_BITS-1:0] s_axis_tdata  = '0;   // [31:0] push_value
    logic [rbd_pkg::CMD_BITS-1:0]   s_axis_tuser  = '0;   // [2:0] command
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [rbd_pkg::VALUE_BITS-1:0] m_axis_tdata;         // [31:0] read_value
    logic [2:0]                     m_axis_tuser;         // [0] ok, [1] is_full, [2] is_empty
    logic                           psel          = 1'b0;
    logic                           penable       = 1'b0;
    logic                           pwrite        = 1'b0;
    logic [rbd_pkg::ADDR_BITS-1:0]  paddr         = '0;
    logic [rbd_pkg::APB_BITS-1:0]   pwdata        = '0;
    logic [rbd_pkg::APB_BITS-1:0]   prdata;
    logic                           pready;

    logic [rbd_pkg::VALUE_BITS-1:0] slot_words [rbd_pkg::SLOTS_DEF];
    int unsigned                    front_slot;
    int unsigned                    back_slot;
    logic [rbd_pkg::RING_BITS-1:0]  ring_reg;

    t_deque_result         expected_results [$];
    int                    failures   = 0;
    bit                    calm       = 1'b0;
    int                    stall_left = 0;

    ring_buffer_deque dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned ring_next(int unsigned p, int unsigned n);
        return (p + 1 >= n) ? 0 : p + 1;
    endfunction

    function automatic int unsigned ring_prev(int unsigned p, int unsigned n);
        return (p == 0) ? n - 1 : p - 1;
    endfunction

    function automatic t_deque_result deque_apply(logic [rbd_pkg::CMD_BITS-1:0] cmd,
                                                  logic [rbd_pkg::VALUE_BITS-1:0] word);
        int unsigned   n;
        bit            was_empty;
        bit            was_full;
        t_deque_result r;
        n = (ring_reg < 2) ? 2 : (ring_reg > rbd_pkg::SLOTS_DEF) ? rbd_pkg::SLOTS_DEF : ring_reg;
        if (front_slot >= n) front_slot = 0;
        if (back_slot >= n) back_slot = 0;
        was_empty = (front_slot == back_slot);
        was_full  = (ring_next(back_slot, n) == front_slot);
        r = '0;
        case (cmd)
            rbd_pkg::CMD_PUSH_BACK: begin
                if (!was_full) begin
                    slot_words[back_slot] = word;
                    back_slot = ring_next(back_slot, n);
                    r.ok = 1'b1;
                end
            end
            rbd_pkg::CMD_PUSH_FRONT: begin
                if (!was_full) begin
                    front_slot = ring_prev(front_slot, n);
                    slot_words[front_slot] = word;
                    r.ok = 1'b1;
                end
            end
            rbd_pkg::CMD_POP_BACK: begin
                if (!was_empty) begin
                    back_slot = ring_prev(back_slot, n);
                    r.read_value = slot_words[back_slot];
                    r.ok = 1'b1;
                end
            end
            rbd_pkg::CMD_POP_FRONT: begin
                if (!was_empty) begin
                    r.read_value = slot_words[front_slot];
                    front_slot = ring_next(front_slot, n);
                    r.ok = 1'b1;
                end
            end
            rbd_pkg::CMD_PEEK_BACK: begin
                if (!was_empty) begin
                    r.read_value = slot_words[ring_prev(back_slot, n)];
                    r.ok = 1'b1;
                end
            end
            rbd_pkg::CMD_PEEK_FRONT: begin
                if (!was_empty) begin
                    r.read_value = slot_words[front_slot];
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.is_full  = (ring_next(back_slot, n) == front_slot);
        r.is_empty = (front_slot == back_slot);
        return r;
    endfunction

    function automatic t_stim_row cmd_row(logic [rbd_pkg::CMD_BITS-1:0] cmd,
                                          logic [rbd_pkg::VALUE_BITS-1:0] word);
        t_stim_row r;
        r = '0;
        r.cmd  = cmd;
        r.word = word;
        return r;
    endfunction

    function automatic t_stim_row typed_row(logic [rbd_pkg::CMD_BITS-1:0] cmd,
                                            logic [rbd_pkg::VALUE_BITS-1:0] word, logic ok,
                                            logic [rbd_pkg::VALUE_BITS-1:0] rd, logic full,
                                            logic empty);
        t_stim_row r;
        r = cmd_row(cmd, word);
        r.typed = 1'b1;
        r.want  = '{ok: ok, read_value: rd, is_full: full, is_empty: empty};
        return r;
    endfunction

    function automatic t_stim_row cfg_row(logic [rbd_pkg::APB_BITS-1:0] word);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.word   = word;
        return r;
    endfunction

    function automatic logic [rbd_pkg::CMD_BITS-1:0] pick_cmd(int push_pct);
        if ($urandom_range(0, 99) < 3) return $urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
        if ($urandom_range(0, 99) < push_pct) begin
            return $urandom_range(0, 1) ? rbd_pkg::CMD_PUSH_FRONT : rbd_pkg::CMD_PUSH_BACK;
        end
        case ($urandom_range(0, 3))
            0:       return rbd_pkg::CMD_POP_BACK;
            1:       return rbd_pkg::CMD_POP_FRONT;
            2:       return rbd_pkg::CMD_PEEK_BACK;
            default: return rbd_pkg::CMD_PEEK_FRONT;
        endcase
    endfunction

    task automatic check_field(string name, logic [rbd_pkg::APB_BITS-1:0] want,
                               logic [rbd_pkg::APB_BITS-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            failures++;
        end
    endtask

    task automatic send_item(logic [rbd_pkg::CMD_BITS-1:0] cmd,
                             logic [rbd_pkg::VALUE_BITS-1:0] word,
                             logic typed, t_deque_result want);
        t_deque_result calc;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        calc = deque_apply(cmd, word);
        expected_results.push_back(typed ? want : calc);
    endtask

    task automatic sender_pause();
        int k;
        if (calm || $urandom_range(0, 3) != 0) return;
        k = $urandom_range(1, 6);
        repeat (k) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
    endtask

    // The queue must be empty of pending results before the ring size changes.
    task automatic write_ring_size(logic [rbd_pkg::APB_BITS-1:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RING_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ring_reg   = value[rbd_pkg::RING_BITS-1:0];
        front_slot = 0;
        back_slot  = 0;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", rbd_pkg::APB_BITS'(ring_reg), prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: read_value %h, flags %b",
                       m_axis_tdata, m_axis_tuser);
                failures++;
            end else begin
                want = expected_results.pop_front();
                check_field("ok", want.ok, m_axis_tuser[0]);
                check_field("read_value", want.read_value, m_axis_tdata);
                check_field("is_full", want.is_full, m_axis_tuser[1]);
                check_field("is_empty", want.is_empty, m_axis_tuser[2]);
            end
        end
    end

    initial begin
        t_stim_row                      plan [$];
        logic [rbd_pkg::RING_BITS-1:0]  phase_sizes [PHASES];
        logic [rbd_pkg::APB_BITS-1:0]   cfg_word;
        logic [rbd_pkg::VALUE_BITS-1:0] word;
        int                   sent;
        int                   seg;
        int                   push_pct;
        phase_sizes = '{5'd2, 5'd16, 5'd0, 5'd5, 5'd31, 5'd1, 5'd17, 5'd9, 5'd3, 5'd16};
        foreach (slot_words[i]) slot_words[i] = '0;
        front_slot = 0;
        back_slot  = 0;
        ring_reg   = rbd_pkg::RING_SIZE_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(typed_row(rbd_pkg::CMD_POP_BACK, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1));
        plan.push_back(typed_row(rbd_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0,
                                 1'b1));
        plan.push_back(typed_row(rbd_pkg::CMD_PEEK_BACK, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1));
        plan.push_back(typed_row(rbd_pkg::CMD_PEEK_FRONT, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1));
        plan.push_back(typed_row(CMD_UNUSED_6, 32'hDEAD_BEEF, 1'b0, 32'h0, 1'b0, 1'b1));
        plan.push_back(typed_row(CMD_UNUSED_7, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1));
        plan.push_back(typed_row(rbd_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0,
                                 1'b0));
        plan.push_back(typed_row(rbd_pkg::CMD_PUSH_FRONT, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0));
        plan.push_back(typed_row(rbd_pkg::CMD_PEEK_BACK, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0,
                                 1'b0));
        plan.push_back(typed_row(rbd_pkg::CMD_PEEK_FRONT, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0));
        plan.push_back(cmd_row(rbd_pkg::CMD_PUSH_BACK, 32'hA5A5_A5A5));
        plan.push_back(cmd_row(rbd_pkg::CMD_PUSH_FRONT, 32'h5A5A_5A5A));
        plan.push_back(cmd_row(rbd_pkg::CMD_POP_BACK, 32'h0));
        plan.push_back(cmd_row(rbd_pkg::CMD_POP_FRONT, 32'h0));
        plan.push_back(cmd_row(rbd_pkg::CMD_POP_FRONT, 32'h0));
        plan.push_back(cmd_row(rbd_pkg::CMD_POP_BACK, 32'h0));
        plan.push_back(cfg_row(32'h0000_0002));
        plan.push_back(typed_row(rbd_pkg::CMD_PUSH_BACK, 32'h8000_0001, 1'b1, 32'h0, 1'b1,
                                 1'b0));
        plan.push_back(typed_row(rbd_pkg::CMD_PUSH_FRONT, 32'h1, 1'b0, 32'h0, 1'b1, 1'b0));
        plan.push_back(typed_row(rbd_pkg::CMD_PUSH_BACK, 32'h2, 1'b0, 32'h0, 1'b1, 1'b0));
        plan.push_back(cmd_row(rbd_pkg::CMD_POP_FRONT, 32'h0));
        plan.push_back(typed_row(rbd_pkg::CMD_POP_BACK, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1));
        plan.push_back(cmd_row(rbd_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFE));
        plan.push_back(cmd_row(rbd_pkg::CMD_POP_BACK, 32'h0));
        plan.push_back(cfg_row(32'hFFFF_FFE0));
        plan.push_back(typed_row(rbd_pkg::CMD_PUSH_BACK, 32'h1234_5678, 1'b1, 32'h0, 1'b1,
                                 1'b0));
        plan.push_back(typed_row(rbd_pkg::CMD_PUSH_FRONT, 32'h0, 1'b0, 32'h0, 1'b1, 1'b0));
        plan.push_back(cmd_row(rbd_pkg::CMD_PEEK_FRONT, 32'h0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_ring_size(plan[i].word);
            end else begin
                send_item(plan[i].cmd, plan[i].word, plan[i].typed, plan[i].want);
                sender_pause();
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            cfg_word = $urandom;
            cfg_word[rbd_pkg::RING_BITS-1:0] = phase_sizes[p];
            write_ring_size(cfg_word);
            if (p == PHASES - 1) calm = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 50;
                    default: push_pct = 15;
                endcase
                seg = $urandom_range(15, 40);
                while (seg > 0 && sent < PHASE_ITEMS) begin
                    case ($urandom_range(0, 9))
                        0:       word = '0;
                        1:       word = '1;
                        default: word = $urandom;
                    endcase
                    send_item(pick_cmd(push_pct), word, 1'b0, '0);
                    sender_pause();
                    seg--;
                    sent++;
                end
                if (p == 4 || (!calm && $urandom_range(0, 9) == 0)) drain();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
